// ===== hdl/rdlt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdlt_pkg
// Shared constants and request codes for the recent device table.
// ----------------------------------------------------------------------------
package rdlt_pkg;

    localparam int ENTRIES_DEF   = 32;
    localparam int TIME_BITS_DEF = 48;
    localparam int MAX_REPORT    = 32;
    localparam int ID_W          = 32;
    localparam int RSSI_W        = 8;
    localparam int OUT_TIME_W    = 48;
    localparam int LIMIT_W       = 6;
    localparam int SLOT_W        = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_REPORT  = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/rdlt_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rdlt_store
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rdlt_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 120
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/recent_device_lru_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// recent_device_lru_table
// Fully associative table of recently seen devices with LRU replacement and
// a report ranked by signal strength. A sequencer scans the entry memory one
// slot per cycle through its single registered read port.
// An observe beat scans every filled slot, then updates its entry and shows the acknowledge.
// A report runs one full scan of the filled slots per result beat.
// Synchronous reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module recent_device_lru_table #(
    parameter int ENTRIES   = rdlt_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = rdlt_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_dev_key,
    input  wire logic [31:0] i_radio_addr,
    input  wire logic [7:0]  i_rssi,
    input  wire logic [47:0] i_now_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_kind,
    output logic [4:0]       o_slot,
    output logic             o_was_hit,
    output logic             o_evicted,
    output logic [31:0]      o_evicted_id,
    output logic [31:0]      o_entry_id,
    output logic [31:0]      o_entry_radio_addr,
    output logic [7:0]       o_entry_rssi,
    output logic [47:0]      o_seen_time_ms,
    output logic             o_entry_valid,
    output logic             o_last_item
);

    localparam int DEPTH = (ENTRIES < rdlt_pkg::MAX_REPORT) ? ENTRIES : rdlt_pkg::MAX_REPORT;
    localparam int SW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int TW    = TIME_BITS;
    localparam int DW    = TW + 72;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_REP  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    r_state;
    logic [5:0]    r_limit;
    logic [FW-1:0] r_fill;
    logic [SW-1:0] r_rank [DEPTH];
    logic [DEPTH-1:0] r_done;

    logic          r_req;
    logic [31:0]   r_id;
    logic [31:0]   r_rf;
    logic [7:0]    r_rssi;
    logic [TW-1:0] r_now;

    logic [FW-1:0] r_cnt;
    logic          r_rvld;
    logic [SW-1:0] r_ridx;
    logic          r_hit;
    logic [SW-1:0] r_tslot;
    logic [DW-1:0] r_tdata;
    logic [SW-1:0] r_lru;
    logic [31:0]   r_lru_id;
    logic          r_found;
    logic [FW-1:0] r_nout;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic [DW-1:0] q;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [FW-1:0] lim;
    logic [31:0]   q_id;
    logic [7:0]    q_rssi;
    logic [7:0]    t_rssi;
    logic          q_better;
    logic          miss_fill;
    logic [SW-1:0] upd_slot;
    logic [SW-1:0] old_rank;

    rdlt_store #(.DEPTH(DEPTH), .AW(SW), .DW(DW)) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (q)
    );

    always_comb begin
        if (r_limit == 6'd0) begin
            lim = FW'(1);
        end else if ({1'b0, r_limit} > 7'(DEPTH)) begin
            lim = FW'(DEPTH);
        end else begin
            lim = FW'(r_limit);
        end
    end

    assign q_id     = q[31:0];
    assign q_rssi   = q[71:64];
    assign t_rssi   = r_tdata[71:64];
    assign q_better = !r_found || (q_rssi > t_rssi) ||
                      ((q_rssi == t_rssi) && (r_rank[r_ridx] < r_rank[r_tslot]));

    assign rd_en   = (r_state == ST_SCAN) && (r_cnt < r_fill);
    assign rd_addr = r_cnt[SW-1:0];

    assign miss_fill = !r_hit && (r_fill < lim);
    always_comb begin
        if (r_hit) begin
            upd_slot = r_tslot;
        end else if (miss_fill) begin
            upd_slot = r_fill[SW-1:0];
        end else begin
            upd_slot = r_lru;
        end
    end
    assign old_rank = r_rank[upd_slot];

    assign wr_en   = (r_state == ST_UPD);
    assign wr_addr = upd_slot;
    assign wr_data = {r_now, r_rssi, (r_hit ? r_tdata[63:32] : r_rf), r_id};

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_limit <= rdlt_pkg::LIMIT_RESET;
            r_fill  <= '0;
            r_done  <= '0;
            r_rvld  <= 1'b0;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_nout  <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_req_type;
                        r_id    <= i_dev_key;
                        r_rf    <= i_radio_addr;
                        r_rssi  <= i_rssi;
                        r_now   <= TW'(i_now_ms);
                        r_cnt   <= '0;
                        r_rvld  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_found <= 1'b0;
                        r_nout  <= '0;
                        r_done  <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_rvld <= rd_en;
                    r_ridx <= rd_addr;
                    if (rd_en) begin
                        r_cnt <= r_cnt + FW'(1);
                    end
                    if (r_rvld) begin
                        if (r_req == rdlt_pkg::REQ_OBSERVE) begin
                            if (q_id == r_id) begin
                                r_hit   <= 1'b1;
                                r_tslot <= r_ridx;
                                r_tdata <= q;
                            end
                            if (r_rank[r_ridx] == SW'(r_fill - FW'(1))) begin
                                r_lru    <= r_ridx;
                                r_lru_id <= q_id;
                            end
                        end else if (!r_done[r_ridx] && q_better) begin
                            r_found <= 1'b1;
                            r_tslot <= r_ridx;
                            r_tdata <= q;
                        end
                    end
                    if (!rd_en && !r_rvld) begin
                        r_state <= (r_req == rdlt_pkg::REQ_OBSERVE) ? ST_UPD : ST_REP;
                    end
                end
                ST_UPD: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (SW'(i) == upd_slot) begin
                            r_rank[i] <= '0;
                        end else if (i < int'(r_fill)) begin
                            if (miss_fill || (r_rank[i] < old_rank)) begin
                                r_rank[i] <= r_rank[i] + SW'(1);
                            end
                        end
                    end
                    if (miss_fill) begin
                        r_fill <= r_fill + FW'(1);
                    end
                    o_valid            <= 1'b1;
                    o_result_kind      <= rdlt_pkg::KIND_ACK;
                    o_slot             <= 5'(upd_slot);
                    o_was_hit          <= r_hit;
                    o_evicted          <= !r_hit && !miss_fill;
                    o_evicted_id       <= (!r_hit && !miss_fill) ? r_lru_id : 32'd0;
                    o_entry_id         <= r_id;
                    o_entry_radio_addr <= r_hit ? r_tdata[63:32] : r_rf;
                    o_entry_rssi       <= r_rssi;
                    o_seen_time_ms     <= 48'(r_now);
                    o_entry_valid      <= 1'b1;
                    o_last_item        <= 1'b1;
                    r_state            <= ST_OUT;
                end
                ST_REP: begin
                    o_valid       <= 1'b1;
                    o_result_kind <= rdlt_pkg::KIND_REPORT;
                    o_was_hit     <= 1'b0;
                    o_evicted     <= 1'b0;
                    o_evicted_id  <= 32'd0;
                    if (r_found) begin
                        r_done[r_tslot]    <= 1'b1;
                        r_nout             <= r_nout + FW'(1);
                        o_slot             <= 5'(r_tslot);
                        o_entry_id         <= r_tdata[31:0];
                        o_entry_radio_addr <= r_tdata[63:32];
                        o_entry_rssi       <= r_tdata[71:64];
                        o_seen_time_ms     <= 48'(r_tdata[DW-1:72]);
                        o_entry_valid      <= 1'b1;
                        o_last_item        <= (r_nout + FW'(1)) == r_fill;
                    end else begin
                        o_slot             <= 5'd0;
                        o_entry_id         <= 32'd0;
                        o_entry_radio_addr <= 32'd0;
                        o_entry_rssi       <= 8'd0;
                        o_seen_time_ms     <= 48'd0;
                        o_entry_valid      <= 1'b0;
                        o_last_item        <= 1'b1;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last_item) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt   <= '0;
                            r_rvld  <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_OUT))
        else $error("Result beat is shown outside the output state.");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("Fill count exceeds the table depth.");
    a_fill_grows_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (r_fill == $past(r_fill) + FW'(1)))
        else $error("Fill count changed by other than one.");
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_SCAN))
        else $error("Accepted beat did not start a scan.");
`endif

endmodule
`default_nettype wire
